/* sv/risi_pkg.sv */
package risi_pkg;

	// opcode bits
	localparam logic [7:0] OP_LAST = 8'h80;
	localparam logic [7:0] OP_REPL = 8'h40;
	localparam logic [7:0] OP_LONG = 8'h04;
	localparam logic [7:0] OP_TEST = 8'h01;
	localparam logic [7:0] OP_DEFINED = OP_LAST | OP_REPL | OP_LONG | OP_TEST;
	// a bare long opcode is taken as a long replicate
	localparam logic [7:0] OP_LONG_ONLY = OP_LONG;
	localparam logic [7:0] OP_LONG_REPL = OP_REPL | OP_LONG;

	// result kinds
	localparam logic [3:0] KIND_WRITE16      = 4'd0;
	localparam logic [3:0] KIND_WRITE32      = 4'd1;
	localparam logic [3:0] KIND_FILL_PAIRS   = 4'd2;
	localparam logic [3:0] KIND_FILL_LONGS   = 4'd3;
	localparam logic [3:0] KIND_BIT_TEST     = 4'd4;
	localparam logic [3:0] KIND_FINISHED     = 4'd5;
	localparam logic [3:0] KIND_BAD_BIT      = 4'd6;
	localparam logic [3:0] KIND_BAD_COMBO    = 4'd7;
	localparam logic [3:0] KIND_LONG_BITTEST = 4'd8;
	localparam logic [3:0] KIND_TIMEOUT      = 4'd9;

	// stream widths
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 128;
	localparam int M_TUSER_W = 4;

	// input mode codes
	localparam logic MODE_BYTE    = 1'b0;
	localparam logic MODE_OUTCOME = 1'b1;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] address;
		logic [31:0] data;
		logic [15:0] second_data;
		logic [29:0] repeat_count;
		logic [7:0]  bit_index;
		logic [7:0]  expected_bit;
		logic        last_of_run;
	} result_t;

endpackage

/* sv/rom_init_sequence_interpreter_top.sv */
// a result is queued as its input beat is taken and is offered on the master side from the queue
// throughput: one input beat per cycle; an input beat makes zero, one or two result beats
// the four-entry result queue sets the rate: s_axis_tready is high while it holds two or fewer
// reset: arst_n clears the decoder to expect an opcode, empties the queue and clears the halt
// after a finished result, an error or a timeout every input beat is taken and dropped until reset
module rom_init_sequence_interpreter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [7:0] rom_byte, [8] test_passed, [15:9] zero
	input  logic [risi_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [0] mode
	input  logic [risi_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [31:0] address, [63:32] data, [79:64] second_data, [109:80] repeat_count,
	// [117:110] bit_index, [125:118] expected_bit, [127:126] zero
	output logic [risi_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [3:0] kind
	output logic [risi_pkg::M_TUSER_W-1:0] m_axis_tuser,
	output logic                           m_axis_tlast
);
	import risi_pkg::*;

	// decoder phases
	localparam logic [2:0] PH_OPCODE  = 3'd0;
	localparam logic [2:0] PH_COUNT   = 3'd1;
	localparam logic [2:0] PH_DEST    = 3'd2;
	localparam logic [2:0] PH_TESTARG = 3'd3;
	localparam logic [2:0] PH_WRITE   = 3'd4;
	localparam logic [2:0] PH_FILL    = 3'd5;
	localparam logic [2:0] PH_WAIT    = 3'd6;

	localparam int QDEPTH = 4;

	// decoder state
	logic [2:0]  phase_q, phase_d;
	logic [7:0]  opcode_q, opcode_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [32:0] rem_q, rem_d;
	logic [31:0] addr_q, addr_d;
	logic [31:0] va_q, va_d;
	logic [15:0] pair_q, pair_d;
	logic        halted_q, halted_d;

	// result queue
	result_t     queue_q [QDEPTH];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  count_q;

	logic        in_accept, out_pop;
	logic        in_mode, in_pass;
	logic [7:0]  in_byte;
	logic        lng;
	logic [2:0]  need_cnt, cnt_inc;
	logic [31:0] va_sh;
	logic [32:0] rem_plus, rem_dec;
	logic        emit0, finish_blk, emit_fin;
	result_t     res0, res_fin, slot0, slot1;
	logic [1:0]  n_push;

	assign in_accept = s_axis_tvalid & s_axis_tready;
	assign out_pop   = m_axis_tvalid & m_axis_tready;
	assign in_mode   = s_axis_tuser[0];
	assign in_byte   = s_axis_tdata[7:0];
	assign in_pass   = s_axis_tdata[8];

	assign lng      = (opcode_q & OP_LONG) != 8'd0;
	assign need_cnt = lng ? 3'd4 : 3'd2;
	assign cnt_inc  = cnt_q + 3'd1;
	assign va_sh    = {va_q[23:0], in_byte};
	assign rem_plus = {1'b0, rem_q[31:0]} + 33'd1;
	assign rem_dec  = (rem_q != 33'd0) ? rem_q - 33'd1 : 33'd0;

	// block decoder, one beat per cycle while s_axis_tready is high
	always_comb begin
		phase_d    = phase_q;
		opcode_d   = opcode_q;
		cnt_d      = cnt_q;
		rem_d      = rem_q;
		addr_d     = addr_q;
		va_d       = va_q;
		pair_d     = pair_q;
		halted_d   = halted_q;
		emit0      = 1'b0;
		finish_blk = 1'b0;
		res0       = '0;
		if (in_accept && !halted_q) begin
			if (phase_q == PH_WAIT) begin
				if (in_mode == MODE_OUTCOME) begin
					if (in_pass) begin
						finish_blk = 1'b1;
					end else begin
						emit0             = 1'b1;
						res0.kind         = KIND_TIMEOUT;
						res0.address      = addr_q;
						res0.bit_index    = va_q[7:0];
						res0.expected_bit = va_q[15:8];
						halted_d          = 1'b1;
					end
				end
			end else if (in_mode == MODE_BYTE) begin
				unique case (phase_q)
					PH_OPCODE: begin
						if ((in_byte & ~OP_DEFINED) != 8'd0) begin
							emit0     = 1'b1;
							res0.kind = KIND_BAD_BIT;
							res0.data = {24'd0, in_byte};
							halted_d  = 1'b1;
						end else if ((in_byte & (OP_REPL | OP_TEST)) == (OP_REPL | OP_TEST)) begin
							emit0     = 1'b1;
							res0.kind = KIND_BAD_COMBO;
							res0.data = {24'd0, in_byte};
							halted_d  = 1'b1;
						end else begin
							opcode_d = (in_byte == OP_LONG_ONLY) ? OP_LONG_REPL : in_byte;
							cnt_d    = 3'd0;
							va_d     = '0;
							phase_d  = PH_COUNT;
						end
					end
					PH_COUNT: begin
						va_d  = va_sh;
						cnt_d = cnt_inc;
						if (!lng || cnt_inc >= 3'd4) begin
							rem_d   = {1'b0, va_sh};
							cnt_d   = 3'd0;
							va_d    = '0;
							phase_d = PH_DEST;
						end
					end
					PH_DEST: begin
						va_d  = va_sh;
						cnt_d = cnt_inc;
						if (cnt_inc >= need_cnt) begin
							addr_d = va_sh;
							cnt_d  = 3'd0;
							va_d   = '0;
							if ((opcode_q & OP_TEST) != 8'd0) begin
								if (lng) begin
									emit0        = 1'b1;
									res0.kind    = KIND_LONG_BITTEST;
									res0.address = va_sh;
									halted_d     = 1'b1;
								end else begin
									phase_d = PH_TESTARG;
								end
							end else if ((opcode_q & OP_REPL) != 8'd0) begin
								phase_d = PH_FILL;
							end else if (lng && rem_q[31]) begin
								// negative long count writes nothing
								rem_d      = '0;
								finish_blk = 1'b1;
							end else begin
								rem_d   = rem_plus;
								phase_d = PH_WRITE;
							end
						end
					end
					PH_TESTARG: begin
						if (cnt_q == 3'd0) begin
							va_d  = {16'd0, in_byte, 8'd0};
							cnt_d = 3'd1;
						end else begin
							va_d              = {16'd0, va_q[15:8], in_byte};
							cnt_d             = 3'd0;
							emit0             = 1'b1;
							res0.kind         = KIND_BIT_TEST;
							res0.address      = addr_q;
							res0.bit_index    = in_byte;
							res0.expected_bit = va_q[15:8];
							phase_d           = PH_WAIT;
						end
					end
					PH_WRITE: begin
						va_d  = va_sh;
						cnt_d = cnt_inc;
						if (cnt_inc >= need_cnt) begin
							emit0        = 1'b1;
							res0.kind    = lng ? KIND_WRITE32 : KIND_WRITE16;
							res0.address = addr_q;
							res0.data    = lng ? va_sh : {16'd0, va_sh[15:0]};
							addr_d       = addr_q + {29'd0, need_cnt};
							cnt_d        = 3'd0;
							va_d         = '0;
							rem_d        = rem_dec;
							if (rem_dec == 33'd0) begin
								finish_blk = 1'b1;
							end
						end
					end
					PH_FILL: begin
						va_d  = va_sh;
						cnt_d = cnt_inc;
						if (lng) begin
							if (cnt_inc >= 3'd4) begin
								emit0        = 1'b1;
								res0.kind    = KIND_FILL_LONGS;
								res0.address = addr_q;
								res0.data    = va_sh;
								res0.repeat_count = rem_q[31] ? 30'd1
									: {1'b0, rem_q[30:2]} + 30'd1;
								finish_blk   = 1'b1;
							end
						end else if (cnt_inc == 3'd2) begin
							pair_d = va_sh[15:0];
							va_d   = '0;
						end else if (cnt_inc >= 3'd4) begin
							emit0             = 1'b1;
							res0.kind         = KIND_FILL_PAIRS;
							res0.address      = addr_q;
							res0.data         = {16'd0, pair_q};
							res0.second_data  = va_sh[15:0];
							res0.repeat_count = {23'd0, rem_q[7:1]} + 30'd1;
							finish_blk        = 1'b1;
						end
					end
					default: begin
						phase_d = PH_OPCODE;
						cnt_d   = 3'd0;
						va_d    = '0;
					end
				endcase
			end
		end
		// end of block: finish the sequence or go for the next opcode
		emit_fin = finish_blk && ((opcode_q & OP_LAST) != 8'd0);
		if (finish_blk) begin
			if (emit_fin) begin
				halted_d = 1'b1;
			end else begin
				phase_d = PH_OPCODE;
			end
			cnt_d = 3'd0;
			va_d  = '0;
		end
	end

	// pack the one or two results of this beat
	always_comb begin
		res_fin             = '0;
		res_fin.kind        = KIND_FINISHED;
		res_fin.last_of_run = 1'b1;
		slot0               = res0;
		slot0.last_of_run   = !emit_fin;
		slot1               = res_fin;
		n_push              = {1'b0, emit0} + {1'b0, emit_fin};
		if (!emit0) begin
			slot0 = res_fin;
		end
	end

	// decoder registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			opcode_q <= '0;
			cnt_q    <= '0;
			rem_q    <= '0;
			addr_q   <= '0;
			va_q     <= '0;
			pair_q   <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			addr_q   <= addr_d;
			va_q     <= va_d;
			pair_q   <= pair_d;
			halted_q <= halted_d;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= slot0;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= slot1;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + {1'b0, out_pop};
			count_q  <= count_q + {1'b0, n_push} - {2'b0, out_pop};
		end
	end

	// stream ports
	assign s_axis_tready = count_q <= 3'd2;
	assign m_axis_tvalid = count_q != 3'd0;
	assign m_axis_tdata  = {2'b00,
		queue_q[rd_ptr_q].expected_bit,
		queue_q[rd_ptr_q].bit_index,
		queue_q[rd_ptr_q].repeat_count,
		queue_q[rd_ptr_q].second_data,
		queue_q[rd_ptr_q].data,
		queue_q[rd_ptr_q].address};
	assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last_of_run;

	// checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(QDEPTH))
		else $error("result queue overflow");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");

	a_no_push_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> n_push == 2'd0)
		else $error("result produced while halted");

	a_pair_ends_finished: assert property (@(posedge clk) disable iff (!arst_n)
		n_push == 2'd2 |-> slot1.kind == KIND_FINISHED && !slot0.last_of_run)
		else $error("second result of a beat is not the finished marker");

	a_finish_halts: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fin |=> halted_q)
		else $error("finished result did not halt the decoder");

endmodule
